### hdl/tween_easing_interpolator_top_defines.svh
// Assertion macros shared by the tween interpolator RTL
`ifndef TWEEN_EASING_INTERPOLATOR_TOP_DEFINES_SVH
`define TWEEN_EASING_INTERPOLATOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define TEI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TEI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TEI_ASSERT_IMPL(lbl, ante, cons, msg)
`define TEI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/tei_pkg.sv
// Types, codes and constant functions shared by the tween interpolator
package tei_pkg;

  // operation codes carried with an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PLAY  = 2'd1;
  localparam logic [1:0] OP_PAUSE = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // run modes
  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_PLAYING = 2'd1;
  localparam logic [1:0] MODE_PAUSED  = 2'd2;
  localparam logic [1:0] MODE_DONE    = 2'd3;

  // register indexes on the configuration port
  localparam int          PADDR_W      = 6;
  localparam logic [2:0] REG_DURATION  = 3'd0;
  localparam logic [2:0] REG_EASE_MODE = 3'd1;
  localparam logic [2:0] REG_LOOP_CNT  = 3'd2;
  localparam logic [2:0] REG_LOOP_MODE = 3'd3;
  localparam logic [2:0] REG_START     = 3'd4;
  localparam logic [2:0] REG_END       = 3'd5;

  // easing curve selectors
  localparam logic [3:0] EASE_SMOOTH         = 4'd1;
  localparam logic [3:0] EASE_SINE_RISE      = 4'd2;
  localparam logic [3:0] EASE_SINE_WAVE      = 4'd3;
  localparam logic [3:0] EASE_SINE_SETTLE    = 4'd4;
  localparam logic [3:0] EASE_INOUT_SINE     = 4'd5;
  localparam logic [3:0] EASE_BACK_PULL      = 4'd6;
  localparam logic [3:0] EASE_BACK_OVERSHOOT = 4'd7;
  localparam logic [3:0] EASE_INOUT_BACK     = 4'd8;

  // how a curve is evaluated
  localparam logic [1:0] KIND_LINEAR = 2'd0;
  localparam logic [1:0] KIND_POLY   = 2'd1;
  localparam logic [1:0] KIND_SINE   = 2'd2;

  // multiplier operand selection
  localparam logic [2:0] MUL_XX  = 3'd0;
  localparam logic [2:0] MUL_CX  = 3'd1;
  localparam logic [2:0] MUL_AB  = 3'd2;
  localparam logic [2:0] MUL_SIN = 3'd3;
  localparam logic [2:0] MUL_CH  = 3'd4;

  localparam logic [14:0] ONE_Q14     = 15'd16384;
  localparam int          DIV_STEPS   = 14;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef struct packed {
    logic [15:0]        duration_ms;
    logic [3:0]         ease_mode;
    logic signed [15:0] loop_count;
    logic               loop_mode;
    logic [63:0]        start_values;
    logic [63:0]        end_values;
  } tei_cfg_t;

  typedef struct packed {
    logic       add_dt;
    logic       play_clr;
    logic       start;
    logic       div_step;
    logic       load_x;
    logic       lin_e;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       load_a;
    logic       load_b;
    logic       poly_fin;
    logic       sin_idx;
    logic       sin_fin;
    logic       flip;
    logic       ch_wr;
    logic [1:0] ch_sel;
    logic       pass_upd;
    logic       out_load;
    logic       out_reset;
    logic       out_done;
    logic       out_last;
  } tei_cmd_t;

  typedef struct packed {
    logic       ended_now;
    logic       ended_q;
    logic       done_hit;
    logic [1:0] kind;
  } tei_sts_t;

  // x = (t << sh) + off; poly: e = asr(mulq(mulq(x,x), mulq(c1,x)+c2) + d, h)
  // sine: angle = x, e = asr(d +/- sin(angle), h)
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         sh;
    logic signed [17:0] off;
    logic signed [17:0] c1;
    logic signed [17:0] c2;
    logic signed [17:0] d;
    logic               h;
    logic               neg;
  } tei_plan_t;

  function automatic tei_plan_t ease_plan(input logic [3:0] mode, input logic [14:0] t);
    tei_plan_t p;
    p = '0;
    unique case (mode)
      EASE_SMOOTH: begin
        p.kind = KIND_POLY; p.c1 = -18'sd32768; p.c2 = 18'sd49152;
      end
      EASE_SINE_RISE: begin
        p.kind = KIND_SINE; p.off = 18'sd16384; p.d = 18'sd16384; p.neg = 1'b1;
      end
      EASE_SINE_WAVE: begin
        p.kind = KIND_SINE; p.sh = 2'd2; p.off = 18'sd49152; p.d = 18'sd16384; p.h = 1'b1;
      end
      EASE_SINE_SETTLE: begin
        p.kind = KIND_SINE;
      end
      EASE_INOUT_SINE: begin
        p.kind = KIND_SINE; p.sh = 2'd1; p.off = 18'sd16384; p.d = 18'sd16384;
        p.h = 1'b1; p.neg = 1'b1;
      end
      EASE_BACK_PULL: begin
        p.kind = KIND_POLY; p.c1 = 18'sd44263; p.c2 = -18'sd27879;
      end
      EASE_BACK_OVERSHOOT: begin
        p.kind = KIND_POLY; p.off = -18'sd16384; p.c1 = 18'sd44263; p.c2 = 18'sd27879;
        p.d = 18'sd16384;
      end
      EASE_INOUT_BACK: begin
        p.kind = KIND_POLY; p.sh = 2'd1; p.c1 = 18'sd58899; p.h = 1'b1;
        if (t < 15'd8192) begin
          p.c2 = -18'sd42515;
        end else begin
          p.off = -18'sd32768; p.c2 = 18'sd42515; p.d = 18'sd32768;
        end
      end
      default: p.kind = KIND_LINEAR;
    endcase
    return p;
  endfunction

  // one quarter-wave entry in Q14 from an angle in Q30 radians
  function automatic logic [15:0] tei_sine_entry(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if (k[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    return 16'((64'(sum) + 64'd32768) >> 16);
  endfunction

endpackage

### hdl/tei_regs.sv
// Configuration register bank on the APB-style port
module tei_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tei_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output tei_pkg::tei_cfg_t           cfg
);
  import tei_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duration_ms  <= 16'd1000;
      cfg.ease_mode    <= 4'd0;
      cfg.loop_count   <= 16'sd1;
      cfg.loop_mode    <= 1'b0;
      cfg.start_values <= 64'd0;
      cfg.end_values   <= 64'd0;
    end else if (wr) begin
      unique case (idx)
        REG_DURATION:  cfg.duration_ms  <= pwdata[15:0];
        REG_EASE_MODE: cfg.ease_mode    <= pwdata[3:0];
        REG_LOOP_CNT:  cfg.loop_count   <= $signed(pwdata[15:0]);
        REG_LOOP_MODE: cfg.loop_mode    <= pwdata[0];
        REG_START:     cfg.start_values <= pwdata;
        REG_END:       cfg.end_values   <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_DURATION:  prdata = 64'(cfg.duration_ms);
      REG_EASE_MODE: prdata = 64'(cfg.ease_mode);
      REG_LOOP_CNT:  prdata = 64'($unsigned(cfg.loop_count));
      REG_LOOP_MODE: prdata = 64'(cfg.loop_mode);
      REG_START:     prdata = cfg.start_values;
      REG_END:       prdata = cfg.end_values;
      default:       prdata = 64'd0;
    endcase
  end

endmodule

### hdl/tei_ctrl.sv
// Sequencer for the tween interpolator: run mode, step order, output handshake
`include "tween_easing_interpolator_top_defines.svh"
module tei_ctrl #(
  parameter int CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic [1:0]        s_op,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              loop_mode,
  input  tei_pkg::tei_sts_t sts,
  output tei_pkg::tei_cmd_t cmd
);
  import tei_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_START = 5'd1;
  localparam logic [4:0] ST_DIV   = 5'd2;
  localparam logic [4:0] ST_EX    = 5'd3;
  localparam logic [4:0] ST_M1    = 5'd4;
  localparam logic [4:0] ST_M2    = 5'd5;
  localparam logic [4:0] ST_B     = 5'd6;
  localparam logic [4:0] ST_M3    = 5'd7;
  localparam logic [4:0] ST_PFIN  = 5'd8;
  localparam logic [4:0] ST_SIDX  = 5'd9;
  localparam logic [4:0] ST_SMUL  = 5'd10;
  localparam logic [4:0] ST_SFIN  = 5'd11;
  localparam logic [4:0] ST_FLIP  = 5'd12;
  localparam logic [4:0] ST_CMUL  = 5'd13;
  localparam logic [4:0] ST_CW    = 5'd14;
  localparam logic [4:0] ST_PASS  = 5'd15;
  localparam logic [4:0] ST_OUT1  = 5'd16;
  localparam logic [4:0] ST_OUT2  = 5'd17;
  localparam logic [1:0] CH_LAST  = 2'(CHANNELS - 1);

  logic [4:0] state, state_next;
  logic [1:0] run_mode, run_mode_next;
  logic [3:0] div_cnt, div_cnt_next;
  logic [1:0] ch_cnt, ch_cnt_next;
  logic       done_q, done_q_next;
  logic       second_q, second_q_next;
  logic       out_valid, out_valid_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  // next state and commands
  always_comb begin
    state_next    = state;
    run_mode_next = run_mode;
    div_cnt_next  = div_cnt;
    ch_cnt_next   = ch_cnt;
    done_q_next   = done_q;
    second_q_next = second_q;
    cmd           = '0;
    cmd.ch_sel    = ch_cnt;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_op)
            OP_PLAY: begin
              if (run_mode != MODE_DONE) begin
                cmd.play_clr  = 1'b1;
                run_mode_next = MODE_PLAYING;
              end
            end
            OP_PAUSE: begin
              if (run_mode == MODE_PLAYING) run_mode_next = MODE_PAUSED;
            end
            OP_TICK: begin
              if (run_mode == MODE_READY || run_mode == MODE_PLAYING) begin
                cmd.add_dt = 1'b1;
                state_next = ST_START;
              end
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        cmd.start    = 1'b1;
        div_cnt_next = 4'd0;
        state_next   = sts.ended_now ? ST_EX : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 4'd1;
        if (div_cnt == 4'(DIV_STEPS - 1)) state_next = ST_EX;
      end
      ST_EX: begin
        cmd.load_x = 1'b1;
        unique case (sts.kind)
          KIND_POLY: state_next = ST_M1;
          KIND_SINE: state_next = ST_SIDX;
          default: begin
            cmd.lin_e  = 1'b1;
            state_next = ST_FLIP;
          end
        endcase
      end
      ST_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XX;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.load_a  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CX;
        state_next  = ST_B;
      end
      ST_B: begin
        cmd.load_b = 1'b1;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AB;
        state_next  = ST_PFIN;
      end
      ST_PFIN: begin
        cmd.poly_fin = 1'b1;
        state_next   = ST_FLIP;
      end
      ST_SIDX: begin
        cmd.sin_idx = 1'b1;
        state_next  = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SIN;
        state_next  = ST_SFIN;
      end
      ST_SFIN: begin
        cmd.sin_fin = 1'b1;
        state_next  = ST_FLIP;
      end
      ST_FLIP: begin
        cmd.flip    = 1'b1;
        ch_cnt_next = 2'd0;
        state_next  = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CH;
        state_next  = ST_CW;
      end
      ST_CW: begin
        cmd.ch_wr = 1'b1;
        if (ch_cnt == CH_LAST) begin
          state_next = ST_PASS;
        end else begin
          ch_cnt_next = ch_cnt + 2'd1;
          state_next  = ST_CMUL;
        end
      end
      ST_PASS: begin
        cmd.pass_upd  = 1'b1;
        done_q_next   = sts.done_hit;
        second_q_next = sts.ended_q && !sts.done_hit && !loop_mode;
        if (sts.done_hit) run_mode_next = MODE_DONE;
        state_next    = ST_OUT1;
      end
      ST_OUT1: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_done = done_q;
          cmd.out_last = !second_q;
          state_next   = second_q ? ST_OUT2 : ST_IDLE;
        end
      end
      ST_OUT2: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_reset = 1'b1;
          cmd.out_last  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hold the output item until taken
  always_comb begin
    if (cmd.out_load)   out_valid_next = 1'b1;
    else if (m_tready)  out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run_mode  <= MODE_READY;
      div_cnt   <= 4'd0;
      ch_cnt    <= 2'd0;
      done_q    <= 1'b0;
      second_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      run_mode  <= run_mode_next;
      div_cnt   <= div_cnt_next;
      ch_cnt    <= ch_cnt_next;
      done_q    <= done_q_next;
      second_q  <= second_q_next;
      out_valid <= out_valid_next;
    end
  end

  `TEI_ASSERT_IMPL(a_out2_needs_second, state == ST_OUT2, second_q, "restart item without a loop")
  `TEI_ASSERT_IMPL(a_done_excl_second, state == ST_OUT1 && done_q, !second_q, "completed run loops")
  `TEI_ASSERT_IMPL(a_div_bound, state == ST_DIV, div_cnt < 4'(DIV_STEPS), "divider overran")
  `TEI_ASSERT_NEXT(a_done_sticks, run_mode == MODE_DONE, run_mode == MODE_DONE, "left completed mode")
  `TEI_ASSERT_NEXT(a_pause_taken, s_tvalid && s_tready && s_op == OP_PAUSE && run_mode == MODE_PLAYING,
                   run_mode == MODE_PAUSED, "pause not taken")

endmodule

### hdl/tei_dp.sv
// Datapath: elapsed time, bit-serial divider, easing with a shared multiplier, channels
module tei_dp #(
  parameter int CHANNELS         = 4,
  parameter int CHANNEL_BITS     = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  tei_pkg::tei_cfg_t cfg,
  input  tei_pkg::tei_cmd_t cmd,
  input  logic [15:0]       dt_ms,
  output tei_pkg::tei_sts_t sts,
  output logic [79:0]       out_data,
  output logic [1:0]        out_user,
  output logic              out_last
);
  import tei_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W = 15 + IDX_W;
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic signed [25:0] SAT_HI = 26'((1 << (CHANNEL_BITS - 1)) - 1);
  localparam logic signed [25:0] SAT_LO = -SAT_HI - 26'sd1;

  logic [16:0]        elapsed;
  logic [15:0]        passes;
  logic               ended_q;
  logic [16:0]        rem;
  logic [14:0]        t;
  logic signed [17:0] x;
  logic signed [23:0] a, b, e;
  logic signed [47:0] p;
  logic [15:0]        lo, hi;
  logic [13:0]        frac;
  logic               wneg;
  logic [15:0]        ch_val [4];

  logic [15:0]        dur;
  logic [17:0]        el_sum;
  logic [16:0]        el_sat;
  logic               ended_now;
  logic [16:0]        rem2;
  logic               div_ge;
  logic [15:0]        passes_inc;
  tei_plan_t          plan;
  logic signed [23:0] p_sh;
  logic [19:0]        tsh;
  logic signed [19:0] xfull;
  logic signed [16:0] s_ch [4];
  logic signed [16:0] d_ch [4];
  logic [15:0]        rst_val [4];
  logic [15:0]        sine_rom [SINE_TABLE_DEPTH+1];
  logic [15:0]        ang;
  logic [14:0]        rr;
  logic [POS_W-1:0]   pos;
  logic [IDX_W-1:0]   idx, lo_idx, hi_idx;
  logic signed [23:0] ma, mb;
  logic signed [23:0] qs, sw, sfin, pfin;
  logic signed [25:0] ch_sum, ch_sat;

  // quarter-wave sine table, worked out at elaboration
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ANGLE = 64'(HALF_PI_Q30 * g / SINE_TABLE_DEPTH);
    assign sine_rom[g] = tei_sine_entry(ANGLE);
  end

  // channel slots, sign-extended from CHANNEL_BITS
  for (genvar c = 0; c < 4; c++) begin : g_slot
    assign s_ch[c]    = 17'($signed(cfg.start_values[16*c +: CHANNEL_BITS]));
    assign d_ch[c]    = 17'($signed(cfg.end_values[16*c +: CHANNEL_BITS])) - s_ch[c];
    assign rst_val[c] = s_ch[c][15:0];
  end

  // time and progress
  assign dur        = (cfg.duration_ms == 16'd0) ? 16'd1 : cfg.duration_ms;
  assign el_sum     = 18'(elapsed) + 18'(dt_ms);
  assign el_sat     = el_sum[17] ? 17'h1FFFF : el_sum[16:0];
  assign ended_now  = elapsed >= 17'(dur);
  assign rem2       = {rem[15:0], 1'b0};
  assign div_ge     = rem2 >= 17'(dur);
  assign passes_inc = (passes == 16'hFFFF) ? passes : passes + 16'd1;
  assign plan       = ease_plan(cfg.ease_mode, t);
  assign p_sh       = 24'(p >>> 14);
  assign tsh        = 20'(t) << plan.sh;
  assign xfull      = $signed(tsh) + 20'(plan.off);

  assign sts.ended_now = ended_now;
  assign sts.ended_q   = ended_q;
  assign sts.kind      = plan.kind;
  assign sts.done_hit  = ended_q && (cfg.loop_count != -16'sd1) &&
                         ($signed({1'b0, passes_inc}) >= 17'(cfg.loop_count));

  // table lookup: fold the angle into one quarter-wave
  always_comb begin
    ang    = x[15:0];
    rr     = ang[14] ? (ONE_Q14 - 15'(ang[13:0])) : {1'b0, ang[13:0]};
    pos    = POS_W'(rr) * POS_W'(SINE_TABLE_DEPTH);
    idx    = pos[14 +: IDX_W];
    lo_idx = (idx >= IDX_END) ? IDX_END : idx;
    hi_idx = (idx >= IDX_END) ? IDX_END : IDX_W'(idx + 1'b1);
  end

  // multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_XX:  begin ma = 24'(x);                      mb = 24'(x); end
      MUL_CX:  begin ma = 24'(plan.c1);                mb = 24'(x); end
      MUL_AB:  begin ma = a;                           mb = b;      end
      MUL_SIN: begin ma = 24'($signed({1'b0, hi}) - $signed({1'b0, lo}));
                     mb = $signed({10'd0, frac}); end
      MUL_CH:  begin ma = 24'(d_ch[cmd.ch_sel]);       mb = e;      end
      default: begin ma = '0;                          mb = '0;     end
    endcase
  end

  // finishing adds for the two curve families and the channel
  always_comb begin
    qs     = $signed({8'd0, lo}) + p_sh;
    sw     = wneg ? -qs : qs;
    sfin   = 24'(plan.d) + (plan.neg ? -sw : sw);
    pfin   = p_sh + 24'(plan.d);
    ch_sum = 26'(s_ch[cmd.ch_sel]) + 26'(p >>> 14);
    if (ch_sum > SAT_HI)      ch_sat = SAT_HI;
    else if (ch_sum < SAT_LO) ch_sat = SAT_LO;
    else                      ch_sat = ch_sum;
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= 17'd0;
      passes  <= 16'd0;
      ended_q <= 1'b0;
    end else begin
      if (cmd.add_dt)        elapsed <= el_sat;
      else if (cmd.play_clr) elapsed <= 17'd0;
      else if (cmd.pass_upd && ended_q) begin
        elapsed <= 17'd0;
        passes  <= passes_inc;
      end
      if (cmd.start) ended_q <= ended_now;
    end
  end

  // divider, easing and channel registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= elapsed;
      t   <= ended_now ? ONE_Q14 : 15'd0;
    end
    if (cmd.div_step) begin
      rem <= div_ge ? (rem2 - 17'(dur)) : rem2;
      t   <= {t[13:0], div_ge};
    end
    if (cmd.load_x)   x <= xfull[17:0];
    if (cmd.lin_e)    e <= 24'(t);
    if (cmd.mul_en)   p <= ma * mb;
    if (cmd.load_a)   a <= p_sh;
    if (cmd.load_b)   b <= p_sh + 24'(plan.c2);
    if (cmd.poly_fin) e <= plan.h ? (pfin >>> 1) : pfin;
    if (cmd.sin_idx) begin
      lo   <= sine_rom[lo_idx];
      hi   <= sine_rom[hi_idx];
      frac <= pos[13:0];
      wneg <= ang[15];
    end
    if (cmd.sin_fin)  e <= plan.h ? (sfin >>> 1) : sfin;
    if (cmd.flip && cfg.loop_mode && passes[0]) e <= 24'(ONE_Q14) - e;
    if (cmd.ch_wr)    ch_val[cmd.ch_sel] <= ch_sat[15:0];
  end

  // output item register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int c = 0; c < 4; c++) begin
        if (c < CHANNELS) out_data[16*c +: 16] <= cmd.out_reset ? rst_val[c] : ch_val[c];
        else              out_data[16*c +: 16] <= 16'd0;
      end
      out_data[79:64] <= cmd.out_reset ? 16'd0 : e[15:0];
      out_user        <= {cmd.out_reset, cmd.out_done};
      out_last        <= cmd.out_last;
    end
  end

endmodule

### hdl/tween_easing_interpolator_top.sv
// Top level of the tween easing interpolator
//
//  port group  | dir | payload
//  s_*         | in  | tdata[15:0] dt_ms; tuser[1:0] operation
//  m_*         | out | tdata ch0..ch3, eased_progress; tuser completed, is_reset_value; tlast
//  p* (APB)    | in  | six registers at byte address 8*index, 64-bit data
//
// After acceptance a tick runs the sequencer through a start step, a restoring divider
// (skipped when the pass ends), easing on one shared 24x24 multiplier, a yoyo step, a
// multiply and a write per channel, a pass update and an output step per item.
// Reset is synchronous and puts the block in ready mode with zero elapsed time;
// a stalled output holds the sequencer at its end.
module tween_easing_interpolator_top #(
  parameter int CHANNELS         = 4,
  parameter int CHANNEL_BITS     = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // dt_ms
  input  logic [1:0]                  s_tuser,   // operation
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [79:0]                 m_tdata,   // channel_0..channel_3, eased_progress
  output logic [1:0]                  m_tuser,   // completed, is_reset_value
  output logic                        m_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tei_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import tei_pkg::*;

  tei_cfg_t cfg;
  tei_cmd_t cmd;
  tei_sts_t sts;

  tei_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  tei_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk, .rst, .s_tvalid, .s_op(s_tuser), .s_tready, .m_tvalid, .m_tready,
    .loop_mode(cfg.loop_mode), .sts, .cmd
  );

  tei_dp #(
    .CHANNELS(CHANNELS), .CHANNEL_BITS(CHANNEL_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk, .rst, .cfg, .cmd, .dt_ms(s_tdata), .sts,
    .out_data(m_tdata), .out_user(m_tuser), .out_last(m_tlast)
  );

endmodule
